// File: rtl/core/sb2d_pkg.sv
// Shared types and constants of the signed binary to decimal ASCII converter.
package sb2d_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic unload;
  } cell_ctrl_t;

endpackage

// File: rtl/core/sb2d_cell.sv
// One BCD digit cell: clear on accept, add-three-and-shift during conversion, digit shift during unload.
module sb2d_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sb2d_pkg::cell_ctrl_t         ctrl_i,
  input  logic                         carry_i,
  input  logic [sb2d_pkg::DIGIT_W-1:0] digit_i,
  output logic                         carry_o,
  output logic [sb2d_pkg::DIGIT_W-1:0] digit_o
);

  logic [sb2d_pkg::DIGIT_W-1:0] digit_q, digit_d, adj;

  assign adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign carry_o = adj[sb2d_pkg::DIGIT_W-1];
  assign digit_o = digit_q;

  always_comb begin
    priority if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[sb2d_pkg::DIGIT_W-2:0], carry_i};
    end else if (ctrl_i.unload) begin
      digit_d = digit_i;
    end else begin
      digit_d = digit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

// File: rtl/core/signed_binary_to_decimal_ascii.sv
// Top level: signed binary to decimal ASCII converter built on a row of BCD digit cells.
// Sequence: accept, then conversion (one magnitude bit per cycle through the cell row),
// then one digit per cycle out of the top cell while the output is not stalled and no
// minus sign is pending. A new value is accepted only in idle, after the last digit has
// entered the output register; the bit-serial pass through the cell row sets the pace.
// Reset: control state, digit cells and output valid clear at once; no clearing pass.
module signed_binary_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [5:0] character, [7:6] zero
  output logic        m_axis_tlast_o
);

  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int unsigned BIT_CNT_W  = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int unsigned DIG_CNT_W  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CONV   = 3'b010,
    ST_UNLOAD = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [VALUE_WIDTH-1:0]          mag_q, mag_d, value_in;
  logic [BIT_CNT_W-1:0]            bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]            dig_cnt_q, dig_cnt_d;
  logic                            minus_pend_q, minus_pend_d;
  logic                            started_q, started_d;
  logic                            out_valid_q, out_valid_d;
  logic [sb2d_pkg::CHAR_W-1:0]     out_char_q, out_char_d;
  logic                            out_last_q, out_last_d;
  logic                            out_free, in_beat;
  sb2d_pkg::cell_ctrl_t            ctrl;
  logic [NUM_DIGITS-1:0]           carry_w;
  logic [sb2d_pkg::DIGIT_W-1:0]    digit_w [NUM_DIGITS];
  logic [sb2d_pkg::DIGIT_W-1:0]    top_digit;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign value_in        = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign top_digit       = digit_w[NUM_DIGITS-1];

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_char_q};
  assign m_axis_tlast_o  = out_last_q;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_low
      sb2d_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .carry_i (mag_q[VALUE_WIDTH-1]),
        .digit_i ('0),
        .carry_o (carry_w[i]),
        .digit_o (digit_w[i])
      );
    end else begin : g_up
      sb2d_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .carry_i (carry_w[i-1]),
        .digit_i (digit_w[i-1]),
        .carry_o (carry_w[i]),
        .digit_o (digit_w[i])
      );
    end
  end

  always_comb begin
    state_d      = state_q;
    mag_d        = mag_q;
    bit_cnt_d    = bit_cnt_q;
    dig_cnt_d    = dig_cnt_q;
    minus_pend_d = minus_pend_q;
    started_d    = started_q;
    out_valid_d  = out_valid_q;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    ctrl         = '0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (minus_pend_q && out_free) begin
      out_valid_d  = 1'b1;
      out_char_d   = sb2d_pkg::ASCII_MINUS;
      out_last_d   = 1'b0;
      minus_pend_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          mag_d        = value_in[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - value_in) : value_in;
          minus_pend_d = value_in[VALUE_WIDTH-1];
          bit_cnt_d    = BIT_CNT_W'(VALUE_WIDTH - 1);
          ctrl.clear   = 1'b1;
          state_d      = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.dabble = 1'b1;
        mag_d       = mag_q << 1;
        bit_cnt_d   = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          dig_cnt_d = DIG_CNT_W'(NUM_DIGITS - 1);
          started_d = 1'b0;
          state_d   = ST_UNLOAD;
        end
      end
      ST_UNLOAD: begin
        if (!minus_pend_q) begin
          if (top_digit == '0 && !started_q && dig_cnt_q != '0) begin
            ctrl.unload = 1'b1;
            dig_cnt_d   = dig_cnt_q - 1'b1;
          end else if (out_free) begin
            ctrl.unload = 1'b1;
            out_valid_d = 1'b1;
            out_char_d  = sb2d_pkg::ASCII_ZERO + sb2d_pkg::CHAR_W'(top_digit);
            out_last_d  = (dig_cnt_q == '0);
            started_d   = 1'b1;
            dig_cnt_d   = dig_cnt_q - 1'b1;
            if (dig_cnt_q == '0) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      bit_cnt_q    <= '0;
      dig_cnt_q    <= '0;
      minus_pend_q <= 1'b0;
      started_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bit_cnt_q    <= bit_cnt_d;
      dig_cnt_q    <= dig_cnt_d;
      minus_pend_q <= minus_pend_d;
      started_q    <= started_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

`ifndef ASSERT_OFF
  a_idle_no_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !minus_pend_q)
    else $error("minus sign still pending in idle");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_char_q == sb2d_pkg::ASCII_MINUS) |-> !out_last_q)
    else $error("minus sign marked last");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_char_q == sb2d_pkg::ASCII_MINUS ||
                     (out_char_q >= sb2d_pkg::ASCII_ZERO &&
                      out_char_q <= sb2d_pkg::ASCII_NINE)))
    else $error("character outside digit range");

  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == ST_CONV))
    else $error("accepted value did not start conversion");
`endif

endmodule
